[sv/line_number_program_engine_macros.svh]
// assertion helpers for the line number program engine
`ifndef LINE_NUMBER_PROGRAM_ENGINE_MACROS_SVH
`define LINE_NUMBER_PROGRAM_ENGINE_MACROS_SVH

// same-cycle implication
`define LNPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LNPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lnpe_pkg.sv]
package lnpe_pkg;

  localparam int DATA_W = 232;

  // configuration register indexes
  localparam logic [2:0] CFG_OP_BASE         = 3'd0;
  localparam logic [2:0] CFG_LN_BASE         = 3'd1;
  localparam logic [2:0] CFG_LN_RANGE        = 3'd2;
  localparam logic [2:0] CFG_INSN_LEN        = 3'd3;
  localparam logic [2:0] CFG_DEFAULT_IS_STMT = 3'd4;
  localparam logic [2:0] CFG_ADDRESS_SIZE    = 3'd5;

  // result kinds
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_STANDARD = 2'd1;
  localparam logic [1:0] ERR_EXTENDED = 2'd2;

  // standard opcodes
  localparam logic [7:0] OP_EXTENDED      = 8'd0;
  localparam logic [7:0] OP_COPY          = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC    = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE  = 8'd3;
  localparam logic [7:0] OP_SET_FILE      = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN    = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT   = 8'd6;
  localparam logic [7:0] OP_BASIC_BLOCK   = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC  = 8'd8;
  localparam logic [7:0] OP_FIXED_ADVANCE = 8'd9;
  localparam logic [7:0] OP_PROLOGUE_END  = 8'd10;
  localparam logic [7:0] OP_EPILOGUE_BEG  = 8'd11;
  localparam logic [7:0] OP_SET_ISA       = 8'd12;

  // extended opcodes
  localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
  localparam logic [7:0] EXT_SET_DISCRIM  = 8'd4;

  // flag bits
  localparam int FL_STMT = 0;
  localparam int FL_BB   = 1;
  localparam int FL_ES   = 2;
  localparam int FL_PE   = 3;
  localparam int FL_EB   = 4;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_LEB, PH_FIXED, PH_EXT_LEN, PH_EXT_CODE, PH_EXT_ADDR, PH_EXT_DISC
  } phase_t;

endpackage

[sv/line_number_program_engine.sv]
// line number program engine
// in_* : one program byte per item (in_tdata[7:0]); in_tready drops while an
//   item is in the arithmetic loop or the result register is full and stalled
// out_*: one row or error result per row-producing item; error_code in out_tuser
// cfg_*: register writes, to be issued only while the block is idle
// most opcodes and operand bytes stay in S_IDLE, so in_tready holds unless the result is stalled
// a special opcode passes through the serial divider (adjusted opcode by
//   the line range), then the shift-add multiplier (quotient times the
//   instruction length), then S_ROW, which loads the row once the output
//   slot is free; the next byte is taken after the row is loaded
// advance_pc uses the multiplier, const_add_pc the divider and the multiplier
// copy, end_sequence and error results appear in the output register in the
//   cycle after the deciding byte
// a stalled receiver holds the result; the next item waits until it is taken
// after an unknown opcode the error result is given, and every later byte
//   is accepted and dropped until reset
// reset (rst_n low, synchronous) loads the default registers, the initial
//   line state and clears the output valid flag
`include "line_number_program_engine_macros.svh"
module line_number_program_engine
  import lnpe_pkg::*;
#(
  parameter int MAX_LEB_BYTES = 10,
  parameter int ADDR_BYTES    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // program_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  // row_address, row_line, row_file, row_column, row_is_stmt, row_basic_block,
  // row_end_sequence, row_prologue_end, row_epilogue_begin, row_isa,
  // row_discriminator, zero pad
  output logic [DATA_W-1:0] out_tdata,
  output logic [1:0]        out_tuser,  // error_code
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata
);

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] LEB_MAX = CNT_W'(MAX_LEB_BYTES);
  localparam logic [3:0] ABYTES = 4'(ADDR_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_ROW} state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [7:0]  ob_r, lr_r, mil_r;
  logic [7:0]  lb_r;
  logic        dis_r;
  logic [3:0]  asz_r;
  logic [63:0] addr_r, addr_nxt;
  logic [31:0] line_r, line_nxt, file_r, file_nxt, col_r, col_nxt;
  logic [31:0] isa_r, isa_nxt, disc_r, disc_nxt;
  logic [4:0]  flags_r, flags_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] nb_r, nb_nxt;
  logic        sticky_r, sticky_nxt;
  logic        special_r, special_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [8:0]  rem_r, rem_nxt, div_r, div_nxt;
  logic [7:0]  dq_r, dq_nxt, mplier_r, mplier_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic        ov_r, ov_nxt;
  logic [DATA_W-1:0] od_r, od_nxt;
  logic [1:0]  ou_r, ou_nxt;

  logic        in_fire, slot_free;
  logic [7:0]  b;
  logic [63:0] leb_acc, fix_acc, adr_acc;
  logic [6:0]  leb_sh, leb_sh_after;
  logic [CNT_W-1:0] leb_nb;
  logic        leb_done;
  logic [3:0]  size_c;
  logic [8:0]  remw;
  logic        qbit;
  logic [8:0]  range9;

  function automatic logic [DATA_W-1:0] pack_row(
    input logic [63:0] a, input logic [31:0] l, input logic [31:0] f,
    input logic [31:0] c, input logic [4:0] fl, input logic [31:0] i,
    input logic [31:0] d);
    pack_row = {3'b000, d, i, fl, c, f, l, a};
  endfunction

  assign slot_free  = !ov_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && slot_free;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign b          = in_tdata;
  assign range9     = (lr_r == 8'd0) ? 9'd256 : {1'b0, lr_r};

  always_comb begin
    leb_sh = 7'(7 * nb_r);
    leb_acc = acc_r;
    leb_nb = nb_r;
    if (nb_r < LEB_MAX) begin
      leb_acc = acc_r | (64'(b[6:0]) << leb_sh);
      leb_nb = nb_r + 1'b1;
    end
    leb_sh_after = 7'(7 * leb_nb);
    leb_done = !b[7];
    fix_acc = acc_r | (64'(b) << (nb_r[0] ? 4'd8 : 4'd0));
    size_c = (asz_r == 4'd0) ? 4'd1 : ((asz_r > ABYTES) ? ABYTES : asz_r);
    adr_acc = (nb_r < 4'(8)) ? (acc_r | (64'(b) << {nb_r[2:0], 3'b000})) : acc_r;
    remw = {rem_r[7:0], dq_r[7]};
    qbit = (remw >= div_r);
  end

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r;
    addr_nxt = addr_r; line_nxt = line_r; file_nxt = file_r; col_nxt = col_r;
    isa_nxt = isa_r; disc_nxt = disc_r; flags_nxt = flags_r;
    pend_nxt = pend_r; acc_nxt = acc_r; nb_nxt = nb_r; sticky_nxt = sticky_r;
    special_nxt = special_r; cnt_nxt = cnt_r; rem_nxt = rem_r; div_nxt = div_r;
    dq_nxt = dq_r; mplier_nxt = mplier_r; mcand_nxt = mcand_r;
    ov_nxt = ov_r; od_nxt = od_r; ou_nxt = ou_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && !sticky_r) begin
          unique case (phase_r)
            PH_OPCODE: begin
              if (b >= ob_r) begin
                special_nxt = 1'b1;
                state_nxt = S_DIV; cnt_nxt = 3'd0;
                rem_nxt = 9'd0; div_nxt = range9; dq_nxt = b - ob_r;
              end else if (b == OP_EXTENDED) begin
                acc_nxt = 64'd0; nb_nxt = '0; phase_nxt = PH_EXT_LEN;
              end else begin
                case (b) inside
                  OP_COPY: begin
                    ov_nxt = 1'b1; ou_nxt = ERR_NONE;
                    od_nxt = pack_row(addr_r, line_r, file_r, col_r, flags_r, isa_r,
                                      disc_r);
                    flags_nxt[FL_BB] = 1'b0;
                  end
                  OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE, OP_SET_COLUMN,
                  OP_SET_ISA: begin
                    pend_nxt = b; acc_nxt = 64'd0; nb_nxt = '0; phase_nxt = PH_LEB;
                  end
                  OP_NEGATE_STMT:  flags_nxt[FL_STMT] = !flags_r[FL_STMT];
                  OP_BASIC_BLOCK:  flags_nxt[FL_BB] = 1'b1;
                  OP_CONST_ADD_PC: begin
                    special_nxt = 1'b0;
                    state_nxt = S_DIV; cnt_nxt = 3'd0;
                    rem_nxt = 9'd0; div_nxt = range9; dq_nxt = 8'd255 - ob_r;
                  end
                  OP_FIXED_ADVANCE: begin
                    acc_nxt = 64'd0; nb_nxt = '0; phase_nxt = PH_FIXED;
                  end
                  OP_PROLOGUE_END: flags_nxt[FL_PE] = 1'b1;
                  OP_EPILOGUE_BEG: flags_nxt[FL_EB] = 1'b1;
                  default: begin
                    ov_nxt = 1'b1; ou_nxt = ERR_STANDARD; od_nxt = '0;
                    sticky_nxt = 1'b1;
                  end
                endcase
              end
            end
            PH_LEB: begin
              acc_nxt = leb_acc; nb_nxt = leb_nb;
              if (leb_done) begin
                phase_nxt = PH_OPCODE;
                case (pend_r)
                  OP_ADVANCE_PC: begin
                    special_nxt = 1'b0; state_nxt = S_MUL; cnt_nxt = 3'd0;
                    mcand_nxt = leb_acc; mplier_nxt = mil_r;
                  end
                  OP_ADVANCE_LINE: begin
                    if (b[6] && leb_sh_after < 7'd64)
                      line_nxt = line_r + 32'(leb_acc | (~64'd0 << leb_sh_after));
                    else
                      line_nxt = line_r + leb_acc[31:0];
                  end
                  OP_SET_FILE:   file_nxt = leb_acc[31:0];
                  OP_SET_COLUMN: col_nxt = leb_acc[31:0];
                  default:       isa_nxt = leb_acc[31:0];
                endcase
              end
            end
            PH_FIXED: begin
              acc_nxt = fix_acc; nb_nxt = nb_r + 1'b1;
              if (nb_r[0]) begin
                addr_nxt = addr_r + fix_acc;
                phase_nxt = PH_OPCODE;
              end
            end
            PH_EXT_LEN: begin
              acc_nxt = leb_acc; nb_nxt = leb_nb;
              if (leb_done) phase_nxt = PH_EXT_CODE;
            end
            PH_EXT_CODE: begin
              unique case (b)
                EXT_END_SEQUENCE: begin
                  ov_nxt = 1'b1; ou_nxt = ERR_NONE;
                  od_nxt = pack_row(addr_r, line_r, file_r, col_r,
                                    flags_r | 5'b00100, isa_r, disc_r);
                  addr_nxt = 64'd0; line_nxt = 32'd1; file_nxt = 32'd1;
                  col_nxt = 32'd0; flags_nxt = {4'b0000, dis_r};
                  isa_nxt = 32'd0; disc_nxt = 32'd0;
                  phase_nxt = PH_OPCODE;
                end
                EXT_SET_ADDRESS: begin
                  acc_nxt = 64'd0; nb_nxt = '0; phase_nxt = PH_EXT_ADDR;
                end
                EXT_SET_DISCRIM: begin
                  acc_nxt = 64'd0; nb_nxt = '0; phase_nxt = PH_EXT_DISC;
                end
                default: begin
                  ov_nxt = 1'b1; ou_nxt = ERR_EXTENDED; od_nxt = '0;
                  sticky_nxt = 1'b1; phase_nxt = PH_OPCODE;
                end
              endcase
            end
            PH_EXT_ADDR: begin
              acc_nxt = adr_acc; nb_nxt = nb_r + 1'b1;
              if ((nb_r + 1'b1) >= size_c) begin
                addr_nxt = adr_acc;
                phase_nxt = PH_OPCODE;
              end
            end
            PH_EXT_DISC: begin
              acc_nxt = leb_acc; nb_nxt = leb_nb;
              if (leb_done) begin
                disc_nxt = leb_acc[31:0];
                phase_nxt = PH_OPCODE;
              end
            end
            default: phase_nxt = PH_OPCODE;
          endcase
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? (remw - div_r) : remw;
        dq_nxt = {dq_r[6:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'd7) begin
          if (special_r)
            line_nxt = line_r + 32'(rem_nxt) + {{24{lb_r[7]}}, lb_r};
          mcand_nxt = 64'(dq_nxt);
          mplier_nxt = mil_r;
          cnt_nxt = 3'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mplier_r[0]) addr_nxt = addr_r + mcand_r;
        mcand_nxt = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'd7) state_nxt = special_r ? S_ROW : S_IDLE;
      end
      S_ROW: begin
        if (slot_free) begin
          ov_nxt = 1'b1; ou_nxt = ERR_NONE;
          od_nxt = pack_row(addr_r, line_r, file_r, col_r, flags_r, isa_r, disc_r);
          flags_nxt[FL_BB] = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; phase_r <= PH_OPCODE;
      ob_r <= 8'd13; lb_r <= 8'hFB; lr_r <= 8'd14; mil_r <= 8'd1;
      dis_r <= 1'b1; asz_r <= 4'd8;
      addr_r <= 64'd0; line_r <= 32'd1; file_r <= 32'd1; col_r <= 32'd0;
      flags_r <= 5'b00001; isa_r <= 32'd0; disc_r <= 32'd0;
      pend_r <= 8'd0; acc_r <= 64'd0; nb_r <= '0; sticky_r <= 1'b0;
      special_r <= 1'b0; cnt_r <= 3'd0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt;
      addr_r <= addr_nxt; line_r <= line_nxt; file_r <= file_nxt; col_r <= col_nxt;
      flags_r <= flags_nxt; isa_r <= isa_nxt; disc_r <= disc_nxt;
      pend_r <= pend_nxt; acc_r <= acc_nxt; nb_r <= nb_nxt; sticky_r <= sticky_nxt;
      special_r <= special_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_OP_BASE:         ob_r <= cfg_wdata;
          CFG_LN_BASE:         lb_r <= cfg_wdata;
          CFG_LN_RANGE:        lr_r <= cfg_wdata;
          CFG_INSN_LEN:        mil_r <= cfg_wdata;
          CFG_DEFAULT_IS_STMT: dis_r <= cfg_wdata[0];
          CFG_ADDRESS_SIZE:    asz_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; div_r <= div_nxt; dq_r <= dq_nxt;
    mplier_r <= mplier_nxt; mcand_r <= mcand_nxt;
    od_r <= od_nxt; ou_r <= ou_nxt;
  end

  `LNPE_ASSERT_NOW(a_busy_not_ready, state_r != S_IDLE, !in_tready, "ready while busy")
  `LNPE_ASSERT_NEXT(a_err_sticky, ov_nxt && !(ov_r && !out_tready) && ou_nxt != ERR_NONE,
                    sticky_r, "error result without sticky error")
  `LNPE_ASSERT_NOW(a_sticky_idle, sticky_r, state_r == S_IDLE, "arithmetic after error")

endmodule

[test/line_number_program_engine_test.sv]
`timescale 1ns / 1ps

module line_number_program_engine_test
  import lnpe_pkg::*;
();

  typedef struct {
    logic [63:0] addr;
    logic [31:0] line;
    logic [31:0] file;
    logic [31:0] col;
    logic [4:0]  flags;
    logic [31:0] isa;
    logic [31:0] disc;
    logic [1:0]  code;
  } line_row_t;

  class line_table_scoreboard;
    logic [7:0] op_base, ln_range, min_insn;
    logic signed [7:0] ln_base;
    logic default_stmt;
    logic [3:0] addr_size;
    line_row_t st;
    phase_t phase;
    logic [7:0] pend_op;
    logic [63:0] accum;
    int nbytes;
    bit sticky;
    line_row_t rows[$];
    int errors;

    function new();
      op_base = 13; ln_base = -5; ln_range = 14; min_insn = 1;
      default_stmt = 1; addr_size = 8;
      init_regs();
      phase = PH_OPCODE; pend_op = 0; accum = 0; nbytes = 0; sticky = 0; errors = 0;
    endfunction

    function void init_regs();
      st.addr = 0; st.line = 1; st.file = 1; st.col = 0;
      st.flags = {4'b0, default_stmt}; st.isa = 0; st.disc = 0; st.code = ERR_NONE;
    endfunction

    function void add_row(line_row_t r);
      rows.insert(rows.size(), r);
    endfunction

    function void write_reg(logic [2:0] a, logic [7:0] d);
      case (a)
        CFG_OP_BASE: op_base = d;
        CFG_LN_BASE: ln_base = d;
        CFG_LN_RANGE: ln_range = d;
        CFG_INSN_LEN: min_insn = d;
        CFG_DEFAULT_IS_STMT: default_stmt = d[0];
        CFG_ADDRESS_SIZE: addr_size = d[3:0];
        default: ;
      endcase
    endfunction

    function void start_operand(phase_t p);
      accum = 0; nbytes = 0; phase = p;
    endfunction

    function bit leb_take(logic [7:0] b);
      int sh;
      if (nbytes < 10) begin
        sh = 7 * nbytes;
        if (sh < 64) accum |= 64'(b[6:0]) << sh;
        nbytes++;
      end
      return !b[7];
    endfunction

    function void raise_error(logic [1:0] c);
      line_row_t r;
      r = '{default: 0};
      r.code = c;
      add_row(r);
      sticky = 1;
      phase = PH_OPCODE;
    endfunction

    function void note_byte(logic [7:0] b);
      int rng, adj, incr, sz, sh;
      rng = (ln_range == 0) ? 256 : int'(ln_range);
      if (sticky) return;
      case (phase)
        PH_OPCODE: begin
          if (b >= op_base) begin
            adj = int'(b) - int'(op_base);
            incr = (adj % rng) + int'(ln_base);
            st.addr += 64'(adj / rng) * 64'(min_insn);
            st.line += 32'(incr);
            add_row(st);
            st.flags[FL_BB] = 0;
          end else begin
            case (b)
              OP_EXTENDED: start_operand(PH_EXT_LEN);
              OP_COPY: begin
                add_row(st);
                st.flags[FL_BB] = 0;
              end
              OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE, OP_SET_COLUMN, OP_SET_ISA: begin
                pend_op = b;
                start_operand(PH_LEB);
              end
              OP_NEGATE_STMT: st.flags[FL_STMT] = !st.flags[FL_STMT];
              OP_BASIC_BLOCK: st.flags[FL_BB] = 1;
              OP_CONST_ADD_PC:
                st.addr += 64'((255 - int'(op_base)) / rng) * 64'(min_insn);
              OP_FIXED_ADVANCE: start_operand(PH_FIXED);
              OP_PROLOGUE_END: st.flags[FL_PE] = 1;
              OP_EPILOGUE_BEG: st.flags[FL_EB] = 1;
              default: raise_error(ERR_STANDARD);
            endcase
          end
        end
        PH_LEB: begin
          if (leb_take(b)) begin
            phase = PH_OPCODE;
            case (pend_op)
              OP_ADVANCE_PC: st.addr += accum * 64'(min_insn);
              OP_ADVANCE_LINE: begin
                sh = 7 * nbytes;
                if (b[6] && sh < 64) accum |= ~64'd0 << sh;
                st.line += accum[31:0];
              end
              OP_SET_FILE: st.file = accum[31:0];
              OP_SET_COLUMN: st.col = accum[31:0];
              default: st.isa = accum[31:0];
            endcase
          end
        end
        PH_FIXED: begin
          accum |= 64'(b) << (8 * (nbytes & 1));
          nbytes++;
          if (nbytes >= 2) begin
            st.addr += accum;
            phase = PH_OPCODE;
          end
        end
        PH_EXT_LEN: if (leb_take(b)) phase = PH_EXT_CODE;
        PH_EXT_CODE: begin
          case (b)
            EXT_END_SEQUENCE: begin
              st.flags[FL_ES] = 1;
              add_row(st);
              init_regs();
              phase = PH_OPCODE;
            end
            EXT_SET_ADDRESS: start_operand(PH_EXT_ADDR);
            EXT_SET_DISCRIM: start_operand(PH_EXT_DISC);
            default: raise_error(ERR_EXTENDED);
          endcase
        end
        PH_EXT_ADDR: begin
          sz = (addr_size < 1) ? 1 : (addr_size > 8) ? 8 : int'(addr_size);
          if (nbytes < 8) accum |= 64'(b) << (8 * nbytes);
          nbytes++;
          if (nbytes >= sz) begin
            st.addr = accum;
            phase = PH_OPCODE;
          end
        end
        PH_EXT_DISC: begin
          if (leb_take(b)) begin
            st.disc = accum[31:0];
            phase = PH_OPCODE;
          end
        end
        default: phase = PH_OPCODE;
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_row(logic [DATA_W-1:0] d, logic [1:0] u);
      line_row_t e;
      if (rows.size() == 0) begin
        report("unexpected row", 64'(u), 64'd0);
        return;
      end
      e = rows.pop_front();
      if (d[63:0] !== e.addr) report("address", d[63:0], e.addr);
      if (d[95:64] !== e.line) report("line", 64'(d[95:64]), 64'(e.line));
      if (d[127:96] !== e.file) report("file", 64'(d[127:96]), 64'(e.file));
      if (d[159:128] !== e.col) report("column", 64'(d[159:128]), 64'(e.col));
      if (d[164:160] !== e.flags) report("flags", 64'(d[164:160]), 64'(e.flags));
      if (d[196:165] !== e.isa) report("isa", 64'(d[196:165]), 64'(e.isa));
      if (d[228:197] !== e.disc)
        report("discriminator", 64'(d[228:197]), 64'(e.disc));
      if (u !== e.code) report("error_code", 64'(u), 64'(e.code));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_we = 0;
  logic [7:0] in_tdata = 0, cfg_wdata = 0;
  logic [2:0] cfg_addr = 0;
  logic in_tready, out_tvalid;
  logic [DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  line_table_scoreboard sb = new();
  int sent = 0;
  int in_idle_pct = 30;
  int out_stall_pct = 30;
  int stall_left = 0;

  line_number_program_engine DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata, out_tuser);
    if (!rst_n) begin
      out_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  function int gap_len();
    if ($urandom_range(0, 99) >= in_idle_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
  endfunction

  task send(logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    sent++;
  endtask

  // random leb with random length, mostly short
  task send_leb();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      send({(i != n - 1) ? 1'b1 : 1'b0, 7'($urandom)});
  endtask

  task send_std(logic [7:0] op);
    if (op >= sb.op_base) begin
      send(op);
      return;
    end
    send(op);
    case (op)
      OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE, OP_SET_COLUMN, OP_SET_ISA: send_leb();
      OP_FIXED_ADVANCE: begin
        send(8'($urandom));
        send(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task send_ext(logic [7:0] code);
    int sz;
    if (sb.op_base == 0) return;
    send(OP_EXTENDED);
    send_leb();
    send(code);
    if (code == EXT_SET_ADDRESS) begin
      sz = (sb.addr_size < 1) ? 1 : (sb.addr_size > 8) ? 8 : int'(sb.addr_size);
      repeat (sz) send(8'($urandom));
    end else if (code == EXT_SET_DISCRIM) begin
      send_leb();
    end
  endtask

  task random_op();
    int k;
    k = $urandom_range(0, 19);
    if (k < 6) send(8'($urandom_range(sb.op_base, 255)));
    else if (k < 17) send_std(8'($urandom_range(OP_COPY, OP_SET_ISA)));
    else if (k == 17) send_ext(EXT_SET_ADDRESS);
    else if (k == 18) send_ext(EXT_SET_DISCRIM);
    else send_ext(EXT_END_SEQUENCE);
  endtask

  task settle();
    if (in_tvalid) in_tvalid <= 0;
    while (sb.rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(logic [2:0] a, logic [7:0] d);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_wdata <= d;
    sb.write_reg(a, d);
  endtask

  task configure(logic [7:0] ob, logic [7:0] lb, logic [7:0] lr, logic [7:0] mi,
                 logic ds, logic [3:0] asz);
    settle();
    write_reg(CFG_OP_BASE, ob);
    write_reg(CFG_LN_BASE, lb);
    write_reg(CFG_LN_RANGE, lr);
    write_reg(CFG_INSN_LEN, mi);
    write_reg(CFG_DEFAULT_IS_STMT, {7'b0, ds});
    write_reg(CFG_ADDRESS_SIZE, {4'b0, asz});
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task run_phase(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) random_op();
    send_ext(EXT_END_SEQUENCE);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed program at reset settings
    send(8'd13);
    send(8'd255);
    send(OP_COPY);
    send(OP_ADVANCE_PC);
    repeat (11) send(8'hff);
    send(8'h01);
    send(OP_ADVANCE_LINE);
    send(8'h40);
    send(OP_SET_FILE);
    send(8'h7f);
    send(OP_SET_COLUMN);
    send(8'h00);
    send(OP_NEGATE_STMT);
    send(OP_BASIC_BLOCK);
    send(OP_CONST_ADD_PC);
    send(OP_FIXED_ADVANCE);
    send(8'hff);
    send(8'hff);
    send(OP_PROLOGUE_END);
    send(OP_EPILOGUE_BEG);
    send(OP_SET_ISA);
    send(8'h85);
    send(8'h02);
    send(OP_COPY);
    send(OP_EXTENDED);
    send(8'h09);
    send(EXT_SET_ADDRESS);
    for (int i = 0; i < 8; i++) send(8'h80 + 8'(i));
    send(OP_EXTENDED);
    send(8'h02);
    send(EXT_SET_DISCRIM);
    send(8'hc3);
    send(8'h01);
    send(OP_COPY);
    send(OP_EXTENDED);
    send(8'h01);
    send(EXT_END_SEQUENCE);
    send(OP_COPY);

    run_phase(200);
    in_idle_pct = 0;
    out_stall_pct = 0;
    configure(8'd10, 8'h80, 8'd255, 8'd255, 1'b0, 4'd4);
    run_phase(220);
    in_idle_pct = 40;
    out_stall_pct = 40;
    configure(8'd255, 8'h7f, 8'd1, 8'd1, 1'b1, 4'd1);
    run_phase(200);
    configure(8'd0, 8'h00, 8'd0, 8'd7, 1'b0, 4'd0);
    run_phase(200);
    configure(8'd1, 8'hf6, 8'd3, 8'd2, 1'b1, 4'd15);
    run_phase(200);
    for (int p = 0; p < 4; p++) begin
      in_idle_pct = $urandom_range(0, 50);
      out_stall_pct = $urandom_range(0, 50);
      configure(8'($urandom_range(13, 40)), 8'($urandom), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 1'($urandom), 4'($urandom_range(1, 8)));
      run_phase(200);
    end

    // unknown standard opcode latches the sticky error, later bytes dropped
    configure(8'd20, 8'hfb, 8'd14, 8'd1, 1'b1, 4'd8);
    send(8'd17);
    send(OP_COPY);
    send(8'd30);
    settle();

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
